[rtl/sym3i_pkg.sv]
// Shared types, widths and codes for the symmetric 3x3 inverse block.
`default_nettype none
package sym3i_pkg;

  localparam int IN_W = 24;
  localparam int OUT_W = 48;
  localparam int IN_FRAC = 12;
  localparam int OUT_FRAC = 24;
  localparam int SHIFT = IN_FRAC + OUT_FRAC;
  localparam int THR_W = 40;
  localparam int PW = 2 * IN_W;
  localparam int CW = 2 * IN_W + 1;
  localparam int CMW = 2 * IN_W;
  localparam int DW = 3 * IN_W + 3;
  localparam int DMW = DW - 1;
  localparam int SPLIT = IN_W + 1;
  localparam int DIV_LAT = OUT_W + 3;
  localparam int FRONT_LAT = 6;
  localparam int PIPE_LAT = FRONT_LAT + DIV_LAT + 1;
  localparam logic [9:0] SYM_ROOT = 10'd1000;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ASYM = 2'd1;
  localparam logic [1:0] ST_SINGULAR = 2'd2;

  typedef struct packed {
    logic signed [IN_W-1:0] a_00;
    logic signed [IN_W-1:0] a_01;
    logic signed [IN_W-1:0] a_02;
    logic signed [IN_W-1:0] a_10;
    logic signed [IN_W-1:0] a_11;
    logic signed [IN_W-1:0] a_12;
    logic signed [IN_W-1:0] a_20;
    logic signed [IN_W-1:0] a_21;
    logic signed [IN_W-1:0] a_22;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv_00;
    logic signed [OUT_W-1:0] inv_11;
    logic signed [OUT_W-1:0] inv_22;
    logic signed [OUT_W-1:0] inv_01;
    logic signed [OUT_W-1:0] inv_02;
    logic signed [OUT_W-1:0] inv_12;
    logic [1:0] status;
    logic saturated;
  } out_t;

endpackage
`default_nettype wire

[rtl/sym3i_div.sv]
// Pipelined restoring divider: cofactor scaled to Q24.24 over the determinant, one bit per stage.
`default_nettype none
module sym3i_div import sym3i_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CW-1:0]    cof,
  input  logic [DMW-1:0]          den,
  input  logic                    den_neg,
  output logic signed [OUT_W-1:0] quo,
  output logic                    sat
);

  localparam int NW = CMW + SHIFT;
  localparam int RW = DMW;

  logic [CMW-1:0] cmag0;
  logic           neg0;
  logic [DMW-1:0] d0;
  logic [NW-1:0]  num;
  logic [OUT_W-1:0] lim;
  logic [OUT_W-1:0] mag;
  logic             sat_c;

  logic [RW-1:0]    rem [0:OUT_W];
  logic [OUT_W-1:0] low [0:OUT_W];
  logic [OUT_W-1:0] q   [0:OUT_W];
  logic [DMW-1:0]   dd  [0:OUT_W];
  logic             ng  [0:OUT_W];
  logic             ov  [0:OUT_W];

  logic [CW-1:0] cof_neg;
  assign cof_neg = CW'(-cof);

  always_ff @(posedge clk) begin
    if (en) begin
      cmag0 <= cof[CW-1] ? cof_neg[CMW-1:0] : cof[CMW-1:0];
      neg0 <= cof[CW-1] ^ den_neg;
      d0 <= den;
    end
  end

  assign num = {cmag0, SHIFT'(0)};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(num[NW-1:OUT_W]);
      ov[0] <= RW'(num[NW-1:OUT_W]) >= d0;
      low[0] <= num[OUT_W-1:0];
      q[0] <= '0;
      dd[0] <= d0;
      ng[0] <= neg0;
    end
  end

  for (genvar k = 0; k < OUT_W; k++) begin : g_step
    logic [RW:0] rs;
    logic [RW:0] df;
    assign rs = {rem[k], low[k][OUT_W-1]};
    assign df = rs - {1'b0, dd[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= df[RW] ? rs[RW-1:0] : df[RW-1:0];
        q[k+1] <= {q[k][OUT_W-2:0], ~df[RW]};
        low[k+1] <= {low[k][OUT_W-2:0], 1'b0};
        dd[k+1] <= dd[k];
        ng[k+1] <= ng[k];
        ov[k+1] <= ov[k];
      end
    end
  end

  always_comb begin
    lim = ng[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    sat_c = ov[OUT_W] || (q[OUT_W] > lim);
    mag = sat_c ? lim : q[OUT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[OUT_W] ? $signed(-mag) : $signed(mag);
      sat <= sat_c;
    end
  end

endmodule
`default_nettype wire

[rtl/symmetric_3x3_inverse_top.sv]
// Throughput: one matrix per cycle while the result side is not stalled;
// six parallel 51-stage divider pipelines set the depth.
// A stalled result holds the whole pipeline until it is taken.
// Reset clears all valid bits and sets the determinant threshold to zero.
// Top level of the symmetric 3x3 cofactor inverse pipeline.
`default_nettype none
module symmetric_3x3_inverse_top import sym3i_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  function automatic logic pair_fail(input logic signed [IN_W-1:0] up,
                                     input logic signed [IN_W-1:0] lo);
    logic signed [IN_W:0] d;
    logic [IN_W:0]        dm;
    logic [IN_W-1:0]      um;
    logic [IN_W+9:0]      scaled;
    d = (IN_W+1)'(up) - (IN_W+1)'(lo);
    dm = d[IN_W] ? (IN_W+1)'(-d) : d;
    um = up[IN_W-1] ? IN_W'(-up) : up;
    scaled = (IN_W+10)'(dm) * (IN_W+10)'(SYM_ROOT);
    return scaled > (IN_W+10)'(um);
  endfunction

  logic [THR_W-1:0] thr;
  logic [PIPE_LAT-1:0] vld;
  logic en;

  logic signed [PW-1:0] pr1 [12];
  logic signed [IN_W-1:0] a1 [3];
  logic signed [IN_W-1:0] a2 [3];
  logic sym1, sym2, sym3, sym4, sym5, sym6;
  logic signed [CW-1:0] c2 [6];
  logic signed [CW-1:0] c3 [6];
  logic signed [CW-1:0] c4 [6];
  logic signed [CW-1:0] c5 [6];
  logic signed [CW-1:0] c6 [6];
  logic signed [IN_W+SPLIT:0] plo3 [3];
  logic signed [PW-1:0] phi3 [3];
  logic signed [DW-1:0] t4 [3];
  logic signed [DW-1:0] det5;
  logic [DW-1:0] det_neg5;
  logic [DMW-1:0] dmag6;
  logic dneg6;
  logic [1:0] st6;
  logic [1:0] stl [DIV_LAT];
  logic signed [OUT_W-1:0] quo [6];
  logic [5:0] sat;
  logic ok;

  localparam int DET_IDX [3] = '{0, 3, 4};

  assign en = ~vld[PIPE_LAT-1] | out_ready;
  assign in_ready = en;
  assign out_valid = vld[PIPE_LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1[0] <= PW'(in_data.a_11) * PW'(in_data.a_22);
      pr1[1] <= PW'(in_data.a_12) * PW'(in_data.a_12);
      pr1[2] <= PW'(in_data.a_00) * PW'(in_data.a_22);
      pr1[3] <= PW'(in_data.a_02) * PW'(in_data.a_02);
      pr1[4] <= PW'(in_data.a_00) * PW'(in_data.a_11);
      pr1[5] <= PW'(in_data.a_01) * PW'(in_data.a_01);
      pr1[6] <= PW'(in_data.a_02) * PW'(in_data.a_12);
      pr1[7] <= PW'(in_data.a_01) * PW'(in_data.a_22);
      pr1[8] <= PW'(in_data.a_01) * PW'(in_data.a_12);
      pr1[9] <= PW'(in_data.a_02) * PW'(in_data.a_11);
      pr1[10] <= PW'(in_data.a_01) * PW'(in_data.a_02);
      pr1[11] <= PW'(in_data.a_12) * PW'(in_data.a_00);
      a1[0] <= in_data.a_00;
      a1[1] <= in_data.a_01;
      a1[2] <= in_data.a_02;
      sym1 <= pair_fail(in_data.a_01, in_data.a_10) | pair_fail(in_data.a_02, in_data.a_20)
            | pair_fail(in_data.a_12, in_data.a_21);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        c2[i] <= CW'(pr1[2*i]) - CW'(pr1[2*i+1]);
      end
      a2 <= a1;
      sym2 <= sym1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo3[j] <= (IN_W+SPLIT+1)'(a2[j])
                 * (IN_W+SPLIT+1)'($signed({1'b0, c2[DET_IDX[j]][SPLIT-1:0]}));
        phi3[j] <= PW'(a2[j]) * PW'($signed(c2[DET_IDX[j]][CW-1:SPLIT]));
      end
      c3 <= c2;
      sym3 <= sym2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        t4[j] <= (DW'(phi3[j]) <<< SPLIT) + DW'(plo3[j]);
      end
      c4 <= c3;
      sym4 <= sym3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det5 <= t4[0] + t4[1] + t4[2];
      c5 <= c4;
      sym5 <= sym4;
    end
  end

  assign det_neg5 = DW'(-det5);

  always_ff @(posedge clk) begin
    if (en) begin
      dmag6 <= det5[DW-1] ? det_neg5[DMW-1:0] : det5[DMW-1:0];
      dneg6 <= det5[DW-1];
      c6 <= c5;
      sym6 <= sym5;
    end
  end

  always_comb begin
    priority if (sym6) begin
      st6 = ST_ASYM;
    end else if (dmag6 <= DMW'(thr)) begin
      st6 = ST_SINGULAR;
    end else begin
      st6 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stl[0] <= st6;
      for (int i = 1; i < DIV_LAT; i++) begin
        stl[i] <= stl[i-1];
      end
    end
  end

  for (genvar i = 0; i < 6; i++) begin : g_div
    sym3i_div u_div (
      .clk     (clk),
      .en      (en),
      .cof     (c6[i]),
      .den     (dmag6),
      .den_neg (dneg6),
      .quo     (quo[i]),
      .sat     (sat[i])
    );
  end

  assign ok = (stl[DIV_LAT-1] == ST_OK);

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.inv_00 <= ok ? quo[0] : '0;
      out_data.inv_11 <= ok ? quo[1] : '0;
      out_data.inv_22 <= ok ? quo[2] : '0;
      out_data.inv_01 <= ok ? quo[3] : '0;
      out_data.inv_02 <= ok ? quo[4] : '0;
      out_data.inv_12 <= ok ? quo[5] : '0;
      out_data.status <= stl[DIV_LAT-1];
      out_data.saturated <= ok & (|sat);
    end
  end

endmodule
`default_nettype wire

[rtl/sym3i_chk.sv]
// Port-level checker for the symmetric 3x3 inverse block, bound to the top level.
`default_nettype none
module sym3i_chk import sym3i_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed before its transfer.");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.inv_00 == '0 && out_data.inv_11 == '0 && out_data.inv_22 == '0 &&
      out_data.inv_01 == '0 && out_data.inv_02 == '0 && out_data.inv_12 == '0 &&
      !out_data.saturated)
    else $error("Error result carries nonzero entries.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_ASYM ||
      out_data.status == ST_SINGULAR)
    else $error("Result status code is invalid.");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind symmetric_3x3_inverse_top sym3i_chk u_sym3i_chk (.*);
`default_nettype wire
